/* sv/dgrw_pkg.sv */
// Shared constants, word types and helper functions for the grid DDA ray walk
package dgrw_pkg;

	localparam int MAP_WIDTH  = 64;
	localparam int MAP_HEIGHT = 64;
	localparam int MAX_STEPS  = 128;

	localparam int CELL_W  = 6;
	localparam int POS_W   = 14;
	localparam int DIST_W  = 32;
	localparam int FRAC_W  = 15;
	localparam int FRAC_SH = 8;
	localparam int PROD_W  = FRAC_W + DIST_W;
	localparam int DIFF_W  = POS_W + 3;

	localparam int XA_W = $clog2(MAP_WIDTH);
	localparam int YA_W = $clog2(MAP_HEIGHT);
	localparam int CX_W = (XA_W > CELL_W) ? XA_W : CELL_W;
	localparam int CY_W = (YA_W > CELL_W) ? YA_W : CELL_W;
	localparam int TX_W = CX_W + 2;
	localparam int TY_W = CY_W + 2;

	localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);
	localparam int SC_W      = $clog2(MAX_STEPS + 1);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_CAST  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_WEST  = 2'd2,
		FACE_EAST  = 2'd3
	} face_t;

	typedef enum logic [1:0] {
		ST_WALL  = 2'd0,
		ST_LEFT  = 2'd1,
		ST_LIMIT = 2'd2,
		ST_WRITE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL_X,
		S_MUL_Y,
		S_MUL_LD,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		req_t              req_type;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic              is_wall;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic              dir_x_negative;
		logic              dir_y_negative;
		logic [DIST_W-1:0] ray_step_x;
		logic [DIST_W-1:0] ray_step_y;
	} in_word_t;

	typedef struct packed {
		logic [CELL_W-1:0] hit_x;
		logic [CELL_W-1:0] hit_y;
		face_t             wall_face;
		logic [DIST_W-1:0] final_side_x;
		logic [DIST_W-1:0] final_side_y;
		status_t           status;
	} out_word_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} ram_wr_t;

	typedef struct packed {
		logic [CELL_W-1:0] coord;
		logic [POS_W-1:0]  pos;
		logic              neg;
		logic [DIST_W-1:0] delta;
	} init_req_t;

	function automatic logic [ADDR_W-1:0] map_addr(input logic [XA_W-1:0] x,
		input logic [YA_W-1:0] y);
		map_addr = ADDR_W'(y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(x);
	endfunction

	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

endpackage

/* sv/dgrw_map_ram.sv */
// Wall bitmap: one bit per cell, one write port, one registered read port
module dgrw_map_ram (
	input  logic                        clk,
	input  dgrw_pkg::ram_wr_t           wr,
	input  logic [dgrw_pkg::ADDR_W-1:0] raddr,
	output logic                        rdata
);
	import dgrw_pkg::*;

	logic mem [MAP_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/dgrw_side_init.sv */
// Initial side distance: clamped cell fraction times delta, shifted and saturated
module dgrw_side_init (
	input  logic                        clk,
	input  dgrw_pkg::init_req_t         req,
	output logic [dgrw_pkg::DIST_W-1:0] side
);
	import dgrw_pkg::*;

	logic [DIFF_W-1:0] cell_lo;
	logic [DIFF_W-1:0] cell_hi;
	logic [DIFF_W-1:0] pos_ext;
	logic [DIFF_W-1:0] diff;
	logic [FRAC_W-1:0] frac;
	logic [PROD_W-1:0] prod_s1;

	assign cell_lo = DIFF_W'({req.coord, {FRAC_SH{1'b0}}});
	assign cell_hi = cell_lo + DIFF_W'(1 << FRAC_SH);
	assign pos_ext = DIFF_W'(req.pos);
	assign diff    = req.neg ? (pos_ext - cell_lo) : (cell_hi - pos_ext);
	assign frac    = diff[DIFF_W-1] ? '0 : diff[FRAC_W-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(frac) * PROD_W'(req.delta);
	end

	assign side = (|prod_s1[PROD_W-1:DIST_W+FRAC_SH]) ? {DIST_W{1'b1}}
		: prod_s1[DIST_W+FRAC_SH-1:FRAC_SH];

endmodule

/* sv/dgrw_walk_ctrl.sv */
// Sequencer: map clear sweep, map writes, side setup and the cell-by-cell walk
module dgrw_walk_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dgrw_pkg::in_word_t          in_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output dgrw_pkg::out_word_t         res_data,
	output dgrw_pkg::ram_wr_t           ram_wr,
	output logic [dgrw_pkg::ADDR_W-1:0] ram_raddr,
	input  logic                        ram_rdata,
	output dgrw_pkg::init_req_t         init_req,
	input  logic [dgrw_pkg::DIST_W-1:0] init_side
);
	import dgrw_pkg::*;

	localparam logic [TX_W-1:0] MAP_W_T = TX_W'(MAP_WIDTH);
	localparam logic [TY_W-1:0] MAP_H_T = TY_W'(MAP_HEIGHT);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [SC_W-1:0]   steps_q;
	logic              pend_q;
	logic [CX_W-1:0]   cur_x_q;
	logic [CY_W-1:0]   cur_y_q;
	logic [DIST_W-1:0] side_x_q;
	logic [DIST_W-1:0] side_y_q;
	logic [DIST_W-1:0] dx_q;
	logic [DIST_W-1:0] dy_q;
	logic [POS_W-1:0]  px_q;
	logic [POS_W-1:0]  py_q;
	logic              nx_q;
	logic              ny_q;
	face_t             face_q;
	out_word_t         res_q;

	logic              step_x;
	logic [DIST_W-1:0] nside_x;
	logic [DIST_W-1:0] nside_y;
	logic [TX_W-1:0]   cx_ext;
	logic [TY_W-1:0]   cy_ext;
	logic [TX_W-1:0]   tx;
	logic [TY_W-1:0]   ty;
	logic              x_past;
	logic              y_past;
	logic              in_map;
	face_t             face_n;
	logic              wr_inside;

	logic    do_write;
	logic    do_cast;
	logic    do_step;
	logic    do_end;
	logic    end_left;
	status_t end_status;

	assign step_x  = side_x_q < side_y_q;
	assign nside_x = step_x ? sat_add(side_x_q, dx_q) : side_x_q;
	assign nside_y = step_x ? side_y_q : sat_add(side_y_q, dy_q);
	assign cx_ext  = TX_W'(cur_x_q);
	assign cy_ext  = TY_W'(cur_y_q);

	always_comb begin
		tx = cx_ext;
		ty = cy_ext;
		if (step_x) begin
			tx = nx_q ? (cx_ext - TX_W'(1)) : (cx_ext + TX_W'(1));
		end else begin
			ty = ny_q ? (cy_ext - TY_W'(1)) : (cy_ext + TY_W'(1));
		end
	end

	assign x_past = !tx[TX_W-1] && ({tx, {FRAC_SH{1'b0}}} > (TX_W+FRAC_SH)'(px_q));
	assign y_past = !ty[TY_W-1] && ({ty, {FRAC_SH{1'b0}}} > (TY_W+FRAC_SH)'(py_q));
	assign face_n = step_x ? (x_past ? FACE_WEST : FACE_EAST)
		: (y_past ? FACE_NORTH : FACE_SOUTH);
	assign in_map = !tx[TX_W-1] && (tx < MAP_W_T) && !ty[TY_W-1] && (ty < MAP_H_T);

	assign ram_raddr = map_addr(tx[XA_W-1:0], ty[YA_W-1:0]);
	assign wr_inside = (TX_W'(in_data.cell_x) < MAP_W_T) && (TY_W'(in_data.cell_y) < MAP_H_T);

	always_comb begin
		if (state_q == S_MUL_X) begin
			init_req = '{coord: cur_x_q[CELL_W-1:0], pos: px_q, neg: nx_q, delta: dx_q};
		end else begin
			init_req = '{coord: cur_y_q[CELL_W-1:0], pos: py_q, neg: ny_q, delta: dy_q};
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		ram_wr     = '0;
		do_write   = 1'b0;
		do_cast    = 1'b0;
		do_step    = 1'b0;
		do_end     = 1'b0;
		end_left   = 1'b0;
		end_status = ST_WALL;
		case (state_q)
			S_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = clr_q;
				ram_wr.data = 1'b0;
				if (clr_q == ADDR_W'(MAP_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.req_type == REQ_WRITE) begin
						do_write    = 1'b1;
						ram_wr.en   = wr_inside;
						ram_wr.addr = map_addr(XA_W'(in_data.cell_x), YA_W'(in_data.cell_y));
						ram_wr.data = in_data.is_wall;
						state_d     = S_FINISH;
					end else begin
						do_cast = 1'b1;
						state_d = S_MUL_X;
					end
				end
			end
			S_MUL_X:  state_d = S_MUL_Y;
			S_MUL_Y:  state_d = S_MUL_LD;
			S_MUL_LD: state_d = S_WALK;
			S_WALK: begin
				if (pend_q && ram_rdata) begin
					do_end     = 1'b1;
					end_status = ST_WALL;
				end else if (steps_q == SC_W'(MAX_STEPS)) begin
					do_end     = 1'b1;
					end_status = ST_LIMIT;
				end else if (!in_map) begin
					do_end     = 1'b1;
					end_left   = 1'b1;
					end_status = ST_LEFT;
				end else begin
					do_step = 1'b1;
				end
				if (do_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			steps_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (do_cast) begin
				steps_q <= '0;
				pend_q  <= 1'b0;
			end else if (do_step) begin
				steps_q <= steps_q + SC_W'(1);
				pend_q  <= 1'b1;
			end else if (do_end) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_cast) begin
			cur_x_q <= CX_W'(in_data.cell_x);
			cur_y_q <= CY_W'(in_data.cell_y);
			px_q    <= in_data.pos_x;
			py_q    <= in_data.pos_y;
			nx_q    <= in_data.dir_x_negative;
			ny_q    <= in_data.dir_y_negative;
			dx_q    <= in_data.ray_step_x;
			dy_q    <= in_data.ray_step_y;
			face_q  <= FACE_NORTH;
		end
		if (state_q == S_MUL_Y) begin
			side_x_q <= init_side;
		end
		if (state_q == S_MUL_LD) begin
			side_y_q <= init_side;
		end
		if (do_step) begin
			cur_x_q  <= tx[CX_W-1:0];
			cur_y_q  <= ty[CY_W-1:0];
			side_x_q <= nside_x;
			side_y_q <= nside_y;
			face_q   <= face_n;
		end
		if (do_write) begin
			res_q.hit_x        <= in_data.cell_x;
			res_q.hit_y        <= in_data.cell_y;
			res_q.wall_face    <= FACE_NORTH;
			res_q.final_side_x <= '0;
			res_q.final_side_y <= '0;
			res_q.status       <= ST_WRITE;
		end
		if (do_end) begin
			res_q.hit_x        <= cur_x_q[CELL_W-1:0];
			res_q.hit_y        <= cur_y_q[CELL_W-1:0];
			res_q.wall_face    <= end_left ? face_n : face_q;
			res_q.final_side_x <= end_left ? nside_x : side_x_q;
			res_q.final_side_y <= end_left ? nside_y : side_y_q;
			res_q.status       <= end_status;
		end
	end

	assign res_data = res_q;

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_WALK)
		else $error("wall check pending outside the walk");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> steps_q <= SC_W'(MAX_STEPS))
		else $error("step count beyond limit");

	a_cell_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ({1'b0, cur_x_q} < (CX_W+1)'(MAP_WIDTH))
			&& ({1'b0, cur_y_q} < (CY_W+1)'(MAP_HEIGHT)))
		else $error("walk reached a cell outside the map");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_step |=> pend_q && (steps_q == $past(steps_q) + SC_W'(1)))
		else $error("step not recorded");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !res_ready) |=> state_q == S_FINISH && $stable(res_q))
		else $error("result dropped before hand-off");

endmodule

/* sv/dda_grid_ray_walk.sv */
// Top level of the grid DDA ray walk: map memory, side setup, sequencer, output register
//
// A write word updates one cell of the 64 x 64 wall map; its result is then offered
// through the result handshake. A cast word goes through the setup states S_MUL_X,
// S_MUL_Y and S_MUL_LD (two passes through one shared 15 x 32 multiplier), then
// walks cell by cell until a step meets a wall, the step count reaches MAX_STEPS
// or the next step would leave the map, and then offers its result. Each step reads
// the map's single read port once and is tested while the next step is worked out.
// After reset the map is swept to open one cell a cycle, all 4096 cells, before the
// first word is taken. Results leave through a one-word output register, so a new
// word is taken while the previous result waits.
module dda_grid_ray_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dgrw_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dgrw_pkg::out_word_t out_data
);
	import dgrw_pkg::*;

	ram_wr_t           ram_wr;
	logic [ADDR_W-1:0] ram_raddr;
	logic              ram_rdata;
	init_req_t         init_req;
	logic [DIST_W-1:0] init_side;
	logic              res_valid;
	logic              res_ready;
	out_word_t         res_data;
	logic              out_valid_q;
	out_word_t         out_data_q;

	dgrw_map_ram u_map (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dgrw_side_init u_init (
		.clk  (clk),
		.req  (init_req),
		.side (init_side)
	);

	dgrw_walk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ram_wr    (ram_wr),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.init_req  (init_req),
		.init_side (init_side)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* tb/ray_walk_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the grid ray walk: shadow wall map, ray predictor and per-field result compare
module ray_walk_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  dgrw_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  dgrw_pkg::out_word_t out_data,
	output int                  errors,
	output int                  pending,
	output int                  n_writes,
	output int                  n_wall_hits,
	output int                  n_exits,
	output int                  n_limits
);
	import dgrw_pkg::*;

	localparam int PRINT_CAP = 100;

	logic      shadow_map [MAP_DEPTH];
	out_word_t expected_results [$];

	task automatic note_mismatch(input string what, input logic [DIST_W-1:0] got,
		input logic [DIST_W-1:0] want);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		end
	endtask

	function automatic logic [DIST_W-1:0] add_clamped(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_clamped = s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] side_start(input logic [CELL_W-1:0] coord,
		input logic [POS_W-1:0] pos, input logic neg, input logic [DIST_W-1:0] delta);
		longint      frac;
		logic [63:0] prod;
		if (neg) begin
			frac = longint'(pos) - longint'(coord) * 256;
		end else begin
			frac = (longint'(coord) + 1) * 256 - longint'(pos);
		end
		if (frac < 0) begin
			frac = 0;
		end
		prod = (64'(frac) * {32'd0, delta}) >> FRAC_SH;
		side_start = (prod > 64'hFFFF_FFFF) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];
	endfunction

	function automatic out_word_t walk_ray(input in_word_t w);
		out_word_t         r;
		int                cx, cy, tx, ty, px, py, steps;
		logic [DIST_W-1:0] sx, sy;
		face_t             face;
		status_t           st;
		cx   = int'(w.cell_x);
		cy   = int'(w.cell_y);
		px   = int'(w.pos_x);
		py   = int'(w.pos_y);
		sx   = side_start(w.cell_x, w.pos_x, w.dir_x_negative, w.ray_step_x);
		sy   = side_start(w.cell_y, w.pos_y, w.dir_y_negative, w.ray_step_y);
		face = FACE_NORTH;
		st   = ST_LIMIT;
		for (steps = 0; steps < MAX_STEPS; steps++) begin
			tx = cx;
			ty = cy;
			if (sx < sy) begin
				sx   = add_clamped(sx, w.ray_step_x);
				tx   = w.dir_x_negative ? cx - 1 : cx + 1;
				face = (tx * 256 > px) ? FACE_WEST : FACE_EAST;
			end else begin
				sy   = add_clamped(sy, w.ray_step_y);
				ty   = w.dir_y_negative ? cy - 1 : cy + 1;
				face = (ty * 256 > py) ? FACE_NORTH : FACE_SOUTH;
			end
			if (tx < 0 || tx >= MAP_WIDTH || ty < 0 || ty >= MAP_HEIGHT) begin
				st = ST_LEFT;
				break;
			end
			cx = tx;
			cy = ty;
			if (shadow_map[map_addr(XA_W'(cx), YA_W'(cy))]) begin
				st = ST_WALL;
				break;
			end
		end
		r.hit_x        = CELL_W'(cx);
		r.hit_y        = CELL_W'(cy);
		r.wall_face    = face;
		r.final_side_x = sx;
		r.final_side_y = sy;
		r.status       = st;
		walk_ray = r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t ack;
		if (!arst_n) begin
			foreach (shadow_map[i]) shadow_map[i] = 1'b0;
			expected_results.delete();
			errors      = 0;
			pending     = 0;
			n_writes    = 0;
			n_wall_hits = 0;
			n_exits     = 0;
			n_limits    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("result with nothing outstanding",
						DIST_W'(out_data.status), '0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.hit_x !== want.hit_x)
						note_mismatch("hit_x", DIST_W'(out_data.hit_x), DIST_W'(want.hit_x));
					if (out_data.hit_y !== want.hit_y)
						note_mismatch("hit_y", DIST_W'(out_data.hit_y), DIST_W'(want.hit_y));
					if (out_data.wall_face !== want.wall_face)
						note_mismatch("wall_face", DIST_W'(out_data.wall_face),
							DIST_W'(want.wall_face));
					if (out_data.final_side_x !== want.final_side_x)
						note_mismatch("final_side_x", out_data.final_side_x, want.final_side_x);
					if (out_data.final_side_y !== want.final_side_y)
						note_mismatch("final_side_y", out_data.final_side_y, want.final_side_y);
					if (out_data.status !== want.status)
						note_mismatch("status", DIST_W'(out_data.status), DIST_W'(want.status));
					case (want.status)
						ST_WRITE: n_writes++;
						ST_WALL:  n_wall_hits++;
						ST_LEFT:  n_exits++;
						default:  n_limits++;
					endcase
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.req_type == REQ_WRITE) begin
					shadow_map[map_addr(XA_W'(in_data.cell_x), YA_W'(in_data.cell_y))] =
						in_data.is_wall;
					ack.hit_x        = in_data.cell_x;
					ack.hit_y        = in_data.cell_y;
					ack.wall_face    = FACE_NORTH;
					ack.final_side_x = '0;
					ack.final_side_y = '0;
					ack.status       = ST_WRITE;
					expected_results.push_back(ack);
				end else begin
					expected_results.push_back(walk_ray(in_data));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the ray walk bench: clock, reset, word stimulus, result back-pressure and verdict
module testbench;
	import dgrw_pkg::*;

	localparam int CYCLE_LIMIT  = 1200000;
	localparam int TAIL_CYCLES  = 200;
	localparam int RANDOM_WORDS = 1500;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PULSE
	} rx_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_word_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_word_t out_data;

	int errors, pending, n_writes, n_wall_hits, n_exits, n_limits;
	int cycle_cnt  = 0;
	int burst_left = 0;

	rx_mode_t   rx_mode  = RX_OPEN;
	int         rx_left  = 0;
	logic [2:0] rx_phase = '0;

	dda_grid_ray_walk u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	ray_walk_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.errors      (errors),
		.pending     (pending),
		.n_writes    (n_writes),
		.n_wall_hits (n_wall_hits),
		.n_exits     (n_exits),
		.n_limits    (n_limits)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("testbench failed");
		$finish;
	end

	always @(negedge clk) begin
		rx_phase <= rx_phase + 3'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(50, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:  out_ready <= 1'b1;
			RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
			default:  out_ready <= (rx_phase == 3'd0);
		endcase
	end

	function automatic in_word_t mk_write(input logic [CELL_W-1:0] cx,
		input logic [CELL_W-1:0] cy, input logic wall);
		in_word_t w;
		w.req_type       = REQ_WRITE;
		w.cell_x         = cx;
		w.cell_y         = cy;
		w.is_wall        = wall;
		w.pos_x          = POS_W'($urandom);
		w.pos_y          = POS_W'($urandom);
		w.dir_x_negative = 1'($urandom);
		w.dir_y_negative = 1'($urandom);
		w.ray_step_x     = $urandom;
		w.ray_step_y     = $urandom;
		mk_write = w;
	endfunction

	function automatic in_word_t mk_cast(input logic [CELL_W-1:0] cx,
		input logic [CELL_W-1:0] cy, input logic [POS_W-1:0] px,
		input logic [POS_W-1:0] py, input logic nx, input logic ny,
		input logic [DIST_W-1:0] dx, input logic [DIST_W-1:0] dy);
		in_word_t w;
		w.req_type       = REQ_CAST;
		w.cell_x         = cx;
		w.cell_y         = cy;
		w.is_wall        = 1'($urandom);
		w.pos_x          = px;
		w.pos_y          = py;
		w.dir_x_negative = nx;
		w.dir_y_negative = ny;
		w.ray_step_x     = dx;
		w.ray_step_y     = dy;
		mk_cast = w;
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(input logic [CELL_W-1:0] coord);
		if ($urandom_range(0, 4) != 0) begin
			pick_pos = {coord, 8'($urandom)};
		end else begin
			pick_pos = POS_W'($urandom);
		end
	endfunction

	function automatic logic [DIST_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: pick_delta = $urandom_range(32'h100, 32'h4_0000);
			4, 5:       pick_delta = $urandom;
			6:          pick_delta = $urandom_range(0, 32'hFFFF);
			7:          pick_delta = '0;
			8:          pick_delta = '1;
			default:    pick_delta = $urandom_range(32'h4_0000, 32'h100_0000);
		endcase
	endfunction

	task automatic send_word(input in_word_t w);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
			                                          : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic drain_pause();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		in_word_t          plan [$];
		int                k;
		logic [CELL_W-1:0] cx, cy;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		plan.push_back(mk_write(6'd0, 6'd0, 1'b1));
		plan.push_back(mk_write(6'd63, 6'd63, 1'b1));
		plan.push_back(mk_write(6'd8, 6'd5, 1'b1));
		plan.push_back(mk_write(6'd5, 6'd8, 1'b1));
		plan.push_back(mk_cast(6'd5, 6'd5, 14'(5*256+128), 14'(5*256+128), 1'b0, 1'b0,
			32'h100, '1));
		plan.push_back(mk_cast(6'd12, 6'd5, 14'(12*256+128), 14'(5*256+128), 1'b1, 1'b0,
			32'h100, '1));
		plan.push_back(mk_cast(6'd5, 6'd5, 14'(5*256+128), 14'(5*256+128), 1'b0, 1'b0,
			'1, 32'h100));
		plan.push_back(mk_cast(6'd5, 6'd12, 14'(5*256+128), 14'(12*256+128), 1'b0, 1'b1,
			'1, 32'h100));
		plan.push_back(mk_cast(6'd0, 6'd0, '0, '0, 1'b0, 1'b0, 32'h1_0000, 32'h1_0000));
		plan.push_back(mk_cast(6'd63, 6'd63, '1, '1, 1'b1, 1'b1, '0, '0));
		plan.push_back(mk_cast(6'd0, 6'd63, '1, '0, 1'b0, 1'b1, '1, '1));
		plan.push_back(mk_cast(6'd0, 6'd0, '1, '0, 1'b1, 1'b0, '1, 32'd1));
		plan.push_back(mk_cast(6'd30, 6'd30, 14'(30*256+64), 14'(30*256+200), 1'b1, 1'b0,
			32'h8000, 32'h8000));
		plan.push_back(mk_write(6'd8, 6'd5, 1'b0));
		plan.push_back(mk_cast(6'd5, 6'd5, 14'(5*256+128), 14'(5*256+128), 1'b0, 1'b0,
			32'h100, '1));
		plan.push_back(mk_cast(6'd63, 6'd10, 14'(63*256+255), 14'(10*256), 1'b0, 1'b0,
			32'h100, 32'h200));
		plan.push_back(mk_cast(6'd10, 6'd0, 14'(10*256+7), 14'd3, 1'b0, 1'b1,
			32'h300, 32'h100));
		plan.push_back(mk_write(6'd63, 6'd0, 1'b0));
		plan.push_back(mk_write(6'd0, 6'd63, 1'b1));
		plan.push_back(mk_cast(6'd0, 6'd0, 14'd128, 14'd128, 1'b0, 1'b0, '1, 32'h100));
		foreach (plan[i]) begin
			send_word(plan[i]);
			pace();
		end
		drain_pause();

		for (k = 0; k < RANDOM_WORDS; k++) begin
			cx = CELL_W'($urandom_range(0, 63));
			cy = CELL_W'($urandom_range(0, 63));
			if ($urandom_range(0, 99) < 40) begin
				send_word(mk_write(cx, cy, $urandom_range(0, 4) != 0));
			end else begin
				send_word(mk_cast(cx, cy, pick_pos(cx), pick_pos(cy), 1'($urandom),
					1'($urandom), pick_delta(), pick_delta()));
			end
			pace();
			if (k % 300 == 299) begin
				drain_pause();
			end
		end
		drain_pause();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d map writes and %0d ray casts", n_writes,
			n_wall_hits + n_exits + n_limits);
		$display("casts ended: %0d on a wall, %0d off the map edge, %0d at the step cap",
			n_wall_hits, n_exits, n_limits);
		if (errors == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
